>>> design/afc_pkg.sv
package afc_pkg;
  localparam int CW = 16;
  localparam int FB = 8;
  localparam int TW = 2*CW + 2;
  localparam int SW = 3*CW + 4;
  localparam int NPLANE = 6;
  localparam int NCORNER = 8;
  localparam int NROW = 3;
  localparam int QDEPTH = 2;

  typedef enum logic {OP_LOAD = 1'b0, OP_TEST = 1'b1} op_t;

  typedef struct packed {
    logic signed [CW-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
  } box_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} bstate_t;
endpackage

>>> design/afc_front.sv
module afc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             op,
  input  logic [1:0]       row,
  input  logic [4*afc_pkg::CW-1:0] mrow,
  input  afc_pkg::box_t    box_in,
  output logic [4*afc_pkg::CW-1:0] rows_o [afc_pkg::NROW],
  input  logic             back_idle,
  output logic             q_valid,
  input  logic             q_ready,
  output afc_pkg::box_t    q_box
);
  import afc_pkg::*;
  logic [4*CW-1:0] rows_r [NROW];
  box_t            q_r [QDEPTH];
  logic [1:0]      cnt_r;
  logic            wp_r, rp_r;
  logic            push, pop;

  // loads only touch rows when no test is queued or running, so a box sees its rows
  assign in_ready = (op == OP_LOAD) ? (cnt_r == 2'd0 && back_idle)
                                    : (cnt_r != 2'(QDEPTH));
  assign push = in_valid && in_ready && op == OP_TEST;
  assign pop  = q_valid && q_ready;
  assign q_valid = cnt_r != 2'd0;
  assign q_box = q_r[rp_r];
  assign rows_o = rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0; wp_r <= 1'b0; rp_r <= 1'b0;
      rows_r[0] <= 64'(1 << FB);
      rows_r[1] <= 64'(1 << FB) << CW;
      rows_r[2] <= 64'(1 << FB) << (2*CW);
    end else begin
      if (in_valid && in_ready && op == OP_LOAD && row != 2'd3) rows_r[row] <= mrow;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
  always_ff @(posedge clk) if (push) q_r[wp_r] <= box_in;
endmodule

>>> design/afc_back.sv
module afc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [4*afc_pkg::CW-1:0] rows_i [afc_pkg::NROW],
  input  logic [4*afc_pkg::CW-1:0] planes_i [afc_pkg::NPLANE],
  input  logic             q_valid,
  output logic             q_ready,
  input  afc_pkg::box_t    q_box,
  output logic             idle,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             visible
);
  import afc_pkg::*;
  bstate_t st_r, st_nxt;
  logic [3:0] c_r;          // corner issue counter, 0..8
  logic       v1_r;         // transform stage valid
  logic       v2_r;         // plane stage valid
  logic [2:0] cc2_r;
  logic signed [TW-1:0] pt_r [NROW];
  logic [NPLANE-1:0] all_out_r;
  logic vis_r;
  box_t box_r;

  logic signed [CW-1:0] vx, vy, vz;
  always_comb begin
    vx = c_r[0] ? box_r.max_x : box_r.min_x;
    vy = c_r[1] ? box_r.max_y : box_r.min_y;
    vz = c_r[2] ? box_r.max_z : box_r.min_z;
  end

  logic signed [TW-1:0] t_nxt [NROW];
  always_comb begin
    for (int r = 0; r < NROW; r++)
      t_nxt[r] = TW'($signed(rows_i[r][CW-1:0]) * vx)
               + TW'($signed(rows_i[r][2*CW-1:CW]) * vy)
               + TW'($signed(rows_i[r][3*CW-1:2*CW]) * vz)
               + (TW'($signed(rows_i[r][4*CW-1:3*CW])) <<< FB);
  end

  logic [NPLANE-1:0] neg;
  always_comb begin
    for (int p = 0; p < NPLANE; p++) begin
      logic signed [SW-1:0] s;
      s = SW'($signed(planes_i[p][CW-1:0]) * pt_r[0])
        + SW'($signed(planes_i[p][2*CW-1:CW]) * pt_r[1])
        + SW'($signed(planes_i[p][3*CW-1:2*CW]) * pt_r[2])
        + (SW'($signed(planes_i[p][4*CW-1:3*CW])) <<< (2*FB));
      neg[p] = s[SW-1];
    end
  end

  always_comb begin
    st_nxt = st_r;
    q_ready = 1'b0;
    out_valid = 1'b0;
    unique case (st_r)
      ST_IDLE: begin q_ready = 1'b1; if (q_valid) st_nxt = ST_RUN; end
      ST_RUN:  if (v2_r && cc2_r == 3'(NCORNER-1)) st_nxt = ST_OUT;
      ST_OUT: begin out_valid = 1'b1; if (out_ready) st_nxt = ST_IDLE; end
      default: st_nxt = ST_IDLE;
    endcase
  end
  assign visible = vis_r;
  assign idle = st_r == ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; c_r <= 4'd0; v1_r <= 1'b0; v2_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_IDLE && q_valid) begin
        box_r <= q_box; c_r <= 4'd0; all_out_r <= '1;
      end
      v1_r <= st_r == ST_RUN && c_r < 4'(NCORNER);
      if (st_r == ST_RUN && c_r < 4'(NCORNER)) begin
        c_r <= c_r + 4'd1;
        pt_r <= t_nxt;
        cc2_r <= c_r[2:0];
      end
      v2_r <= v1_r;
      if (v1_r) begin
        all_out_r <= all_out_r & neg;
        if (cc2_r == 3'(NCORNER-1)) vis_r <= ~|(all_out_r & neg);
      end
    end
  end
endmodule

>>> design/aabb_frustum_cull.sv
// Six-plane frustum cull of an axis-aligned box under a 3x4 affine transform.
// Load requests (op 0) write one transform row (row 3 is dropped); test
// requests (op 1) return one visible flag. Planes must be written on the cfg
// port only while idle; the block itself does not enforce this. In the back
// end a box is taken from the queue in the idle state, its corners go one
// corner a cycle through the shared transform and six-plane dot unit, the
// transform and plane stages drain and the result is held until taken; a
// stalled result holds the back end. A two-entry queue holds boxes ahead of
// it; a load waits until that queue is empty and the back end is idle.
module aabb_frustum_cull (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,    // op
  input  logic [167:0] in_tdata,   // row, m0..m3, min_x..min_z, max_x..max_z, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // visible, pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import afc_pkg::*;
  logic [4*CW-1:0] planes_r [NPLANE];
  logic [4*CW-1:0] rows [NROW];
  logic q_valid, q_ready, vis, back_idle;
  box_t box, q_box;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NPLANE; p++) planes_r[p] <= '0;
    end else if (cfg_we && cfg_index < 3'(NPLANE)) begin
      planes_r[cfg_index] <= cfg_wdata;
    end
  end

  assign box.min_x = in_tdata[81:66];
  assign box.min_y = in_tdata[97:82];
  assign box.min_z = in_tdata[113:98];
  assign box.max_x = in_tdata[129:114];
  assign box.max_y = in_tdata[145:130];
  assign box.max_z = in_tdata[161:146];

  afc_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .op(in_tuser),
    .row(in_tdata[1:0]), .mrow(in_tdata[65:2]), .box_in(box), .rows_o(rows),
    .back_idle, .q_valid, .q_ready, .q_box
  );

  afc_back u_back (
    .clk, .rst_n, .rows_i(rows), .planes_i(planes_r), .q_valid, .q_ready, .q_box,
    .idle(back_idle), .out_valid(out_tvalid), .out_ready(out_tready), .visible(vis)
  );

  assign out_tdata = {7'd0, vis};
endmodule
